// ===== sv/xfv_pkg.sv =====
// Package for the XOR frame validator: shared types and fixed constants.
// Used by the register block, controller, datapath and top level.
package xfv_pkg;

    localparam logic [7:0] HEAD_MARK   = 8'hAA;
    localparam int         FRAME_EXTRA = 8;
    localparam logic [8:0] POS_MAX     = 9'd511;

    // Status codes of a result.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_HEADER   = 3'd1;
    localparam logic [2:0] ST_COMMAND  = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_LENGTH   = 3'd4;
    localparam logic [2:0] ST_CHECKSUM = 3'd5;

    // Register byte addresses on the configuration port.
    localparam int         ADDR_W         = 4;
    localparam logic [3:0] ADDR_WRITE_CODE = 4'h0;
    localparam logic [3:0] ADDR_READ_CODE  = 4'h4;
    localparam logic [3:0] ADDR_REPLY_CODE = 4'h8;

    typedef struct packed {
        logic [7:0] write_code;
        logic [7:0] read_code;
        logic [7:0] reply_code;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // an input request is taken this cycle
        logic rd;       // read the payload store at the current index
        logic advance;  // move on to the next payload byte
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;     // the result on show is the last one of the frame
    } t_dp_stat;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  command;
        logic [7:0]  start_offset;
        logic [7:0]  payload_length;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        byte_valid;
        logic [31:0] error_total;
        logic [31:0] good_total;
        logic        run_last;
    } t_result;

endpackage

// ===== sv/xfv_if.sv =====
// Stream interfaces of the XOR frame validator: received bytes in, results out.
// Each carries valid, ready and the payload; no dependencies.
interface xfv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, rx_byte, frame_end, input ready);
    modport sink   (input valid, rx_byte, frame_end, output ready);
endinterface

interface xfv_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  command;
    logic [7:0]  start_offset;
    logic [7:0]  payload_length;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        byte_valid;
    logic [31:0] error_total;
    logic [31:0] good_total;
    logic        run_last;

    modport source (output valid, status, command, start_offset, payload_length,
                    payload_byte, payload_index, byte_valid, error_total,
                    good_total, run_last, input ready);
    modport sink   (input valid, status, command, start_offset, payload_length,
                    payload_byte, payload_index, byte_valid, error_total,
                    good_total, run_last, output ready);
endinterface

// ===== sv/xfv_regs.sv =====
// Configuration registers of the XOR frame validator behind an APB-style port.
// Depends on xfv_pkg for the register addresses and the t_cfg type.
module xfv_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [xfv_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output xfv_pkg::t_cfg              o_cfg
);
    import xfv_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.write_code <= 8'd1;
            r_cfg.read_code  <= 8'd2;
            r_cfg.reply_code <= 8'd3;
        end else if (w_wr) begin
            unique case (paddr)
                ADDR_WRITE_CODE: r_cfg.write_code <= pwdata[7:0];
                ADDR_READ_CODE:  r_cfg.read_code  <= pwdata[7:0];
                ADDR_REPLY_CODE: r_cfg.reply_code <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_WRITE_CODE: prdata = {24'd0, r_cfg.write_code};
            ADDR_READ_CODE:  prdata = {24'd0, r_cfg.read_code};
            ADDR_REPLY_CODE: prdata = {24'd0, r_cfg.reply_code};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// ===== sv/xfv_ctrl.sv =====
// Controller of the XOR frame validator: receive, store read and result phases.
// Depends on xfv_pkg for the command and status structs.
module xfv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_frame_end,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  xfv_pkg::t_dp_stat i_stat,
    output xfv_pkg::t_dp_cmd  o_cmd
);
    import xfv_pkg::*;

    typedef enum logic [2:0] {
        S_RX  = 3'b001,
        S_RD  = 3'b010,
        S_OUT = 3'b100
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready    = (r_state == S_RX);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_cmd.accept  = (r_state == S_RX) && i_in_valid;
    assign o_cmd.rd      = (r_state == S_RD);
    assign o_cmd.advance = (r_state == S_OUT) && i_out_ready && !i_stat.last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RX: begin
                if (i_in_valid && i_in_frame_end) n_state = S_RD;
            end
            S_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = i_stat.last ? S_RX : S_RD;
            end
            default: n_state = S_RX;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RX;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/xfv_dp.sv =====
// Datapath of the XOR frame validator: frame checks, payload store, counters
// and result registers. Depends on xfv_pkg; driven by xfv_ctrl commands.
module xfv_dp #(
    parameter int TABLE_BYTES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xfv_pkg::t_cfg     i_cfg,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_frame_end,
    input  xfv_pkg::t_dp_cmd  i_cmd,
    output xfv_pkg::t_dp_stat o_stat,
    output xfv_pkg::t_result  o_result
);
    import xfv_pkg::*;

    localparam int AW = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;
    localparam int IW = $clog2(TABLE_BYTES + 1);

    // Per-frame state and running counters.
    logic [8:0]  r_pos;
    logic [7:0]  r_xor;
    logic [2:0]  r_first_err;
    logic [7:0]  r_cmd_b, r_off_b, r_len_b;
    logic [31:0] r_err_cnt, r_good_cnt;

    // Result registers, loaded at the end of a frame.
    logic [2:0]    r_res_status;
    logic [7:0]    r_res_cmd, r_res_off, r_res_len;
    logic          r_pay_mode;
    logic [IW-1:0] r_n;
    logic [IW-1:0] r_idx;
    logic [7:0]    r_rd_data;

    logic [7:0] r_mem [TABLE_BYTES];

    logic [7:0] n_cmd_b, n_off_b, n_len_b;
    logic [2:0] w_pos_err, w_cnt_err, w_fe1, w_fe2, w_fe3, w_fe4;
    logic [9:0] w_count;
    logic [8:0] w_slot;
    logic       w_store, w_ok;

    always_comb begin
        n_cmd_b   = (r_pos == 9'd4) ? i_rx_byte : r_cmd_b;
        n_off_b   = (r_pos == 9'd5) ? i_rx_byte : r_off_b;
        n_len_b   = (r_pos == 9'd6) ? i_rx_byte : r_len_b;
        w_pos_err = ST_OK;
        if (r_pos < 9'd4) begin
            if (i_rx_byte != HEAD_MARK) w_pos_err = ST_HEADER;
        end else if (r_pos == 9'd4) begin
            if (i_rx_byte != i_cfg.write_code && i_rx_byte != i_cfg.read_code &&
                i_rx_byte != i_cfg.reply_code) w_pos_err = ST_COMMAND;
        end else if (r_pos == 9'd6) begin
            if ({1'b0, r_off_b} + {1'b0, i_rx_byte} > 9'(TABLE_BYTES))
                w_pos_err = ST_RANGE;
        end
        w_fe1 = (r_first_err != ST_OK) ? r_first_err : w_pos_err;

        // Checks that only the final byte can settle, each kept only if none failed before.
        w_count = {1'b0, r_pos} + 10'd1;
        if (w_count < 10'd4)      w_cnt_err = ST_HEADER;
        else if (w_count < 10'd5) w_cnt_err = ST_COMMAND;
        else if (w_count < 10'd7) w_cnt_err = ST_RANGE;
        else                      w_cnt_err = ST_OK;
        w_fe2 = (w_fe1 != ST_OK) ? w_fe1 : w_cnt_err;
        w_fe3 = w_fe2;
        if (w_fe2 == ST_OK && w_count != {2'b00, n_len_b} + 10'(FRAME_EXTRA))
            w_fe3 = ST_LENGTH;
        w_fe4 = w_fe3;
        if (w_fe3 == ST_OK && r_xor != i_rx_byte) w_fe4 = ST_CHECKSUM;
        w_ok = (w_fe4 == ST_OK);

        w_slot  = r_pos - 9'd7;
        w_store = (r_pos >= 9'd7) && (w_slot < {1'b0, r_len_b}) &&
                  (w_slot < 9'(TABLE_BYTES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 9'd0;
            r_xor       <= 8'd0;
            r_first_err <= ST_OK;
            r_cmd_b     <= 8'd0;
            r_off_b     <= 8'd0;
            r_len_b     <= 8'd0;
            r_err_cnt   <= 32'd0;
            r_good_cnt  <= 32'd0;
            r_pay_mode  <= 1'b0;
            r_idx       <= '0;
        end else if (i_cmd.accept) begin
            if (i_frame_end) begin
                r_pos       <= 9'd0;
                r_xor       <= 8'd0;
                r_first_err <= ST_OK;
                r_cmd_b     <= 8'd0;
                r_off_b     <= 8'd0;
                r_len_b     <= 8'd0;
                r_pay_mode  <= w_ok && (n_len_b != 8'd0);
                r_idx       <= '0;
                if (w_ok) r_good_cnt <= r_good_cnt + 32'd1;
                else      r_err_cnt  <= r_err_cnt + 32'd1;
            end else begin
                r_xor       <= r_xor ^ i_rx_byte;
                r_first_err <= w_fe1;
                r_cmd_b     <= n_cmd_b;
                r_off_b     <= n_off_b;
                r_len_b     <= n_len_b;
                if (r_pos < POS_MAX) r_pos <= r_pos + 9'd1;
            end
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_frame_end) begin
            r_res_status <= w_fe4;
            r_res_cmd    <= w_ok ? n_cmd_b : 8'd0;
            r_res_off    <= w_ok ? n_off_b : 8'd0;
            r_res_len    <= w_ok ? n_len_b : 8'd0;
            if ({1'b0, n_len_b} > 9'(TABLE_BYTES)) r_n <= IW'(TABLE_BYTES);
            else                                   r_n <= IW'(n_len_b);
        end
    end

    // Payload store: one write port from the receive side, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_store) r_mem[w_slot[AW-1:0]] <= i_rx_byte;
        if (i_cmd.rd) r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    assign o_stat.last = !r_pay_mode || (IW'(r_idx + IW'(1)) == r_n);

    assign o_result.status         = r_res_status;
    assign o_result.command        = r_res_cmd;
    assign o_result.start_offset   = r_res_off;
    assign o_result.payload_length = r_res_len;
    assign o_result.payload_byte   = r_pay_mode ? r_rd_data : 8'd0;
    assign o_result.payload_index  = r_pay_mode ? 8'(r_idx) : 8'd0;
    assign o_result.byte_valid     = r_pay_mode;
    assign o_result.error_total    = r_err_cnt;
    assign o_result.good_total     = r_good_cnt;
    assign o_result.run_last       = o_stat.last;

endmodule

// ===== sv/xor_frame_validator_top.sv =====
// XOR frame validator top level. Bytes are taken while the controller receives.
// After the last byte the first result shows once the store read state is passed;
// each further payload result follows the taking of the previous one through a new
// store read state, for the registered read of the payload store. No byte is taken
// while results are pending. Synchronous active-low reset clears all frame state
// and counters at once, with no clearing pass, and sets the command codes to 1, 2, 3.
module xor_frame_validator_top #(
    parameter int TABLE_BYTES = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    xfv_in_if.sink                     i_in,
    xfv_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [xfv_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import xfv_pkg::*;

    t_cfg     w_cfg;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    t_result  w_res;

    xfv_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    xfv_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .i_in_frame_end (i_in.frame_end),
        .o_in_ready     (i_in.ready),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .i_stat         (w_stat),
        .o_cmd          (w_cmd)
    );

    xfv_dp #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_rx_byte   (i_in.rx_byte),
        .i_frame_end (i_in.frame_end),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_result    (w_res)
    );

    assign o_out.status         = w_res.status;
    assign o_out.command        = w_res.command;
    assign o_out.start_offset   = w_res.start_offset;
    assign o_out.payload_length = w_res.payload_length;
    assign o_out.payload_byte   = w_res.payload_byte;
    assign o_out.payload_index  = w_res.payload_index;
    assign o_out.byte_valid     = w_res.byte_valid;
    assign o_out.error_total    = w_res.error_total;
    assign o_out.good_total     = w_res.good_total;
    assign o_out.run_last       = w_res.run_last;

endmodule
